// ===== rtl/qrs_pkg.sv =====
// Shared widths, types and root arithmetic helpers for the quadratic root solver.
package qrs_pkg;

  localparam int COEF_W  = 16;
  localparam int MAG_W   = COEF_W;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int DISC_W  = PROD_W + 2;
  localparam int FRAC_W  = 16;
  localparam int RAD_W   = DISC_W + 2 * FRAC_W;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int PM_W    = MAG_W + FRAC_W;
  localparam int NUM_W   = ROOT_W + 1;
  localparam int DEN_W   = MAG_W + 1;
  localparam int DREM_W  = DEN_W + 1;
  localparam int OUT_W   = 41;

  typedef enum logic [1:0] {
    KIND_LINEAR   = 2'd0,
    KIND_EQUAL    = 2'd1,
    KIND_DISTINCT = 2'd2,
    KIND_COMPLEX  = 2'd3
  } root_kind_t;

  typedef struct packed {
    root_kind_t        kind;
    logic              an;
    logic              pneg;
    logic [PM_W-1:0]   pm;
    logic [DEN_W-1:0]  den;
  } qrs_sq_side_t;

  typedef struct packed {
    root_kind_t        kind;
    logic              neg1;
    logic              neg2;
    logic [DEN_W-1:0]  den;
  } qrs_div_side_t;

  typedef struct packed {
    logic              neg;
    logic [NUM_W-1:0]  mag;
  } qrs_part_t;

  function automatic qrs_part_t part_calc(logic pneg, logic [PM_W-1:0] pm, logic rneg,
                                          logic [ROOT_W-1:0] s, logic exact);
    qrs_part_t        r;
    logic [NUM_W-1:0] pmx;
    logic [NUM_W-1:0] sx;
    pmx = NUM_W'(pm);
    sx  = NUM_W'(s);
    if (pm == '0 || pneg == rneg) begin
      r.neg = (pm != '0) ? pneg : rneg;
      r.mag = pmx + sx;
    end else if (pmx > sx || (pmx == sx && exact)) begin
      r.neg = pneg;
      r.mag = pmx - sx - NUM_W'(!exact);
    end else begin
      r.neg = rneg;
      r.mag = sx - pmx;
    end
    return r;
  endfunction

endpackage

// ===== rtl/quadratic_root_solver_unit.sv =====
// Top level of the quadratic root solver: products, discriminant, root and division pipeline.
//
//   channel  signals                              direction
//   in       in_valid, in_stall, coef_a/b/c       transaction in
//   out      out_valid, out_stall, root_kind,     transaction out
//            first_value, second_value
//
// One transaction enters per cycle while not stalled; it passes the 33-stage square root
// and the 34-stage divider plus four stages of products, discriminant, root parts and output.
// Reset clears only the valid bits of every stage.
// While a finished result is held by out_stall the whole pipeline holds and in_stall is high.
module quadratic_root_solver_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        root_kind,
  output logic signed [qrs_pkg::OUT_W-1:0]  first_value,
  output logic signed [qrs_pkg::OUT_W-1:0]  second_value
);

  localparam int CW = qrs_pkg::COEF_W;
  localparam int MW = qrs_pkg::MAG_W;
  localparam int PW = qrs_pkg::PROD_W;
  localparam int DW = qrs_pkg::DISC_W;
  localparam int NW = qrs_pkg::NUM_W;
  localparam int OW = qrs_pkg::OUT_W;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [MW-1:0] am;
  logic [MW-1:0] bm;
  logic [MW-1:0] cm;
  assign am = coef_a[CW-1] ? MW'(-coef_a) : MW'(coef_a);
  assign bm = coef_b[CW-1] ? MW'(-coef_b) : MW'(coef_b);
  assign cm = coef_c[CW-1] ? MW'(-coef_c) : MW'(coef_c);

  logic          s1_valid;
  logic          s1_an;
  logic          s1_bn;
  logic          s1_add;
  logic [MW-1:0] s1_am;
  logic [MW-1:0] s1_bm;
  logic [PW-1:0] s1_sq;
  logic [PW-1:0] s1_ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_an  <= coef_a[CW-1];
      s1_bn  <= coef_b[CW-1];
      s1_add <= (coef_a[CW-1] != coef_c[CW-1]) && (cm != '0);
      s1_am  <= am;
      s1_bm  <= bm;
      s1_sq  <= PW'(bm) * PW'(bm);
      s1_ac  <= PW'(am) * PW'(cm);
    end
  end

  logic [DW-1:0]       prod4;
  logic [DW-1:0]       sqx;
  logic [DW-1:0]       dm;
  logic                dneg;
  qrs_pkg::root_kind_t kind2;

  assign prod4 = {s1_ac, 2'b00};
  assign sqx   = DW'(s1_sq);

  always_comb begin
    dneg = 1'b0;
    if (s1_add) begin
      dm = sqx + prod4;
    end else if (sqx >= prod4) begin
      dm = sqx - prod4;
    end else begin
      dm   = prod4 - sqx;
      dneg = 1'b1;
    end
    if (s1_am == '0) begin
      kind2 = qrs_pkg::KIND_LINEAR;
    end else if (dm == '0) begin
      kind2 = qrs_pkg::KIND_EQUAL;
    end else if (!dneg) begin
      kind2 = qrs_pkg::KIND_DISTINCT;
    end else begin
      kind2 = qrs_pkg::KIND_COMPLEX;
    end
  end

  logic                        s2_valid;
  logic [qrs_pkg::RAD_W-1:0]   s2_rad;
  qrs_pkg::qrs_sq_side_t       s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_rad       <= {dm, {(2 * qrs_pkg::FRAC_W){1'b0}}};
      s2_side.kind <= kind2;
      s2_side.an   <= s1_an;
      s2_side.pneg <= !s1_bn;
      s2_side.pm   <= {s1_bm, {qrs_pkg::FRAC_W{1'b0}}};
      s2_side.den  <= {s1_am, 1'b0};
    end
  end

  logic                        sq_valid;
  logic [qrs_pkg::ROOT_W-1:0]  sq_root;
  logic                        sq_exact;
  qrs_pkg::qrs_sq_side_t       sq_side;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s2_valid),
    .rad       (s2_rad),
    .side_in   (s2_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .exact     (sq_exact),
    .side_out  (sq_side)
  );

  qrs_pkg::qrs_part_t p_mid;
  qrs_pkg::qrs_part_t p_plus;
  qrs_pkg::qrs_part_t p_minus;
  qrs_pkg::qrs_part_t p1;
  qrs_pkg::qrs_part_t p2;

  always_comb begin
    p_mid   = qrs_pkg::part_calc(sq_side.pneg, sq_side.pm, 1'b0, '0, 1'b1);
    p_plus  = qrs_pkg::part_calc(sq_side.pneg, sq_side.pm, 1'b0, sq_root, sq_exact);
    p_minus = qrs_pkg::part_calc(sq_side.pneg, sq_side.pm, 1'b1, sq_root, sq_exact);
    case (sq_side.kind)
      qrs_pkg::KIND_LINEAR: begin
        p1 = '0;
        p2 = '0;
      end
      qrs_pkg::KIND_EQUAL: begin
        p1 = p_mid;
        p2 = p_mid;
      end
      qrs_pkg::KIND_DISTINCT: begin
        p1 = p_plus;
        p2 = p_minus;
      end
      qrs_pkg::KIND_COMPLEX: begin
        p1     = p_mid;
        p2.neg = 1'b0;
        p2.mag = NW'(sq_root);
      end
      default: begin
        p1 = '0;
        p2 = '0;
      end
    endcase
  end

  logic                   s3_valid;
  logic [NW-1:0]          s3_num1;
  logic [NW-1:0]          s3_num2;
  qrs_pkg::qrs_div_side_t s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= sq_valid;
    end
    if (en) begin
      s3_num1      <= p1.mag;
      s3_num2      <= p2.mag;
      s3_side.kind <= sq_side.kind;
      s3_side.neg1 <= p1.neg != sq_side.an;
      s3_side.neg2 <= p2.neg != sq_side.an;
      s3_side.den  <= sq_side.den;
    end
  end

  logic                   dv_valid;
  logic [NW-1:0]          dv_q1;
  logic [NW-1:0]          dv_q2;
  qrs_pkg::qrs_div_side_t dv_side;

  qrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .num1      (s3_num1),
    .num2      (s3_num2),
    .side_in   (s3_side),
    .out_valid (dv_valid),
    .quo1      (dv_q1),
    .quo2      (dv_q2),
    .side_out  (dv_side)
  );

  logic [OW-1:0] q1x;
  logic [OW-1:0] q2x;
  logic [OW-1:0] lim_pos;
  logic [OW-1:0] lim_neg;
  logic          n1;
  logic          n2;
  logic [OW-1:0] v1;
  logic [OW-1:0] v2;

  assign lim_pos = {1'b0, {(OW-1){1'b1}}};
  assign lim_neg = {1'b1, {(OW-1){1'b0}}};
  assign q1x     = OW'(dv_q1);
  assign q2x     = OW'(dv_q2);
  assign n1      = dv_side.neg1 && (dv_q1 != '0);
  assign n2      = dv_side.neg2 && (dv_q2 != '0);

  always_comb begin
    if (dv_side.kind == qrs_pkg::KIND_LINEAR) begin
      v1 = '0;
      v2 = '0;
    end else begin
      if (n1) begin
        v1 = (q1x > lim_neg) ? lim_neg : (~q1x + OW'(1));
      end else begin
        v1 = (q1x > lim_pos) ? lim_pos : q1x;
      end
      if (n2) begin
        v2 = (q2x > lim_neg) ? lim_neg : (~q2x + OW'(1));
      end else begin
        v2 = (q2x > lim_pos) ? lim_pos : q2x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid;
    end
    if (en) begin
      root_kind    <= dv_side.kind;
      first_value  <= v1;
      second_value <= v2;
    end
  end

endmodule

// ===== rtl/qrs_sqrt.sv =====
// Pipelined restoring integer square root, one result bit per stage.
module qrs_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [qrs_pkg::RAD_W-1:0]     rad,
  input  qrs_pkg::qrs_sq_side_t         side_in,
  output logic                          out_valid,
  output logic [qrs_pkg::ROOT_W-1:0]    root,
  output logic                          exact,
  output qrs_pkg::qrs_sq_side_t         side_out
);

  localparam int STEPS = qrs_pkg::ROOT_W;
  localparam int RW    = qrs_pkg::RAD_W;
  localparam int MW    = qrs_pkg::REM_W;
  localparam int TW    = qrs_pkg::ROOT_W;

  logic                  vld   [0:STEPS];
  logic [RW-1:0]         rad_q [0:STEPS];
  logic [MW-1:0]         rem_q [0:STEPS];
  logic [TW-1:0]         rt_q  [0:STEPS];
  qrs_pkg::qrs_sq_side_t sd_q  [0:STEPS];

  assign vld[0]   = in_valid;
  assign rad_q[0] = rad;
  assign rem_q[0] = '0;
  assign rt_q[0]  = '0;
  assign sd_q[0]  = side_in;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [MW-1:0] rem_sh;
    logic [MW-1:0] trial;
    logic          ge;
    assign rem_sh = {rem_q[i][MW-3:0], rad_q[i][RW-1:RW-2]};
    assign trial  = MW'({rt_q[i], 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rad_q[i+1] <= {rad_q[i][RW-3:0], 2'b00};
        rem_q[i+1] <= ge ? (rem_sh - trial) : rem_sh;
        rt_q[i+1]  <= {rt_q[i][TW-2:0], ge};
        sd_q[i+1]  <= sd_q[i];
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign root      = rt_q[STEPS];
  assign exact     = (rem_q[STEPS] == '0);
  assign side_out  = sd_q[STEPS];

endmodule

// ===== rtl/qrs_div.sv =====
// Pipelined two-lane restoring divider sharing one divisor, one quotient bit per stage.
module qrs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [qrs_pkg::NUM_W-1:0]     num1,
  input  logic [qrs_pkg::NUM_W-1:0]     num2,
  input  qrs_pkg::qrs_div_side_t        side_in,
  output logic                          out_valid,
  output logic [qrs_pkg::NUM_W-1:0]     quo1,
  output logic [qrs_pkg::NUM_W-1:0]     quo2,
  output qrs_pkg::qrs_div_side_t        side_out
);

  localparam int STEPS = qrs_pkg::NUM_W;
  localparam int NW    = qrs_pkg::NUM_W;
  localparam int RW    = qrs_pkg::DREM_W;

  logic                   vld  [0:STEPS];
  logic [NW-1:0]          n1_q [0:STEPS];
  logic [NW-1:0]          n2_q [0:STEPS];
  logic [RW-1:0]          r1_q [0:STEPS];
  logic [RW-1:0]          r2_q [0:STEPS];
  qrs_pkg::qrs_div_side_t sd_q [0:STEPS];

  assign vld[0]  = in_valid;
  assign n1_q[0] = num1;
  assign n2_q[0] = num2;
  assign r1_q[0] = '0;
  assign r2_q[0] = '0;
  assign sd_q[0] = side_in;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [RW-1:0] d;
    logic [RW-1:0] s1;
    logic [RW-1:0] s2;
    logic          ge1;
    logic          ge2;
    assign d   = RW'(sd_q[i].den);
    assign s1  = {r1_q[i][RW-2:0], n1_q[i][NW-1]};
    assign s2  = {r2_q[i][RW-2:0], n2_q[i][NW-1]};
    assign ge1 = s1 >= d;
    assign ge2 = s2 >= d;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        n1_q[i+1] <= {n1_q[i][NW-2:0], ge1};
        n2_q[i+1] <= {n2_q[i][NW-2:0], ge2};
        r1_q[i+1] <= ge1 ? (s1 - d) : s1;
        r2_q[i+1] <= ge2 ? (s2 - d) : s2;
        sd_q[i+1] <= sd_q[i];
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign quo1      = n1_q[STEPS];
  assign quo2      = n2_q[STEPS];
  assign side_out  = sd_q[STEPS];

endmodule

// ===== verif/tb_quadratic_root_solver_unit.sv =====
// Self-checking testbench for the quadratic root solver: random and directed coefficient sets.
`timescale 1ns / 1ps

module tb_quadratic_root_solver_unit;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int QUIET_TAIL     = 150;
  localparam int DRAIN_CYCLES   = 150;

  typedef struct {
    logic signed [qrs_pkg::COEF_W-1:0] a;
    logic signed [qrs_pkg::COEF_W-1:0] b;
    logic signed [qrs_pkg::COEF_W-1:0] c;
  } coef_set_t;

  typedef struct {
    qrs_pkg::root_kind_t              kind;
    logic signed [qrs_pkg::OUT_W-1:0] v1;
    logic signed [qrs_pkg::OUT_W-1:0] v2;
  } roots_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [qrs_pkg::COEF_W-1:0] coef_a = '0;
  logic signed [qrs_pkg::COEF_W-1:0] coef_b = '0;
  logic signed [qrs_pkg::COEF_W-1:0] coef_c = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] root_kind;
  logic signed [qrs_pkg::OUT_W-1:0] first_value;
  logic signed [qrs_pkg::OUT_W-1:0] second_value;

  coef_set_t pending_sets[$];
  roots_t    expected_roots[$];
  int        error_count = 0;
  int        roots_checked = 0;
  int        idle_cycles = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  quadratic_root_solver_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .root_kind(root_kind), .first_value(first_value), .second_value(second_value)
  );

  always #4 clk = ~clk;

  function automatic logic signed [qrs_pkg::OUT_W-1:0] scaled_quotient(logic neg,
                                                                        longint unsigned mag,
                                                                        logic den_neg,
                                                                        longint unsigned den);
    longint unsigned q;
    longint unsigned lim;
    logic            n;
    q   = mag / den;
    n   = (neg != den_neg) && q != 0;
    lim = (64'd1 << (qrs_pkg::OUT_W - 1)) - (n ? 64'd0 : 64'd1);
    if (q > lim) q = lim;
    return n ? -qrs_pkg::OUT_W'(q) : qrs_pkg::OUT_W'(q);
  endfunction

  function automatic logic signed [qrs_pkg::OUT_W-1:0] root_part(logic pneg,
                                                                  longint unsigned pm,
                                                                  logic rneg,
                                                                  longint unsigned s,
                                                                  logic exact, logic den_neg,
                                                                  longint unsigned den);
    logic            yneg;
    longint unsigned ym;
    if (pm == 0 || pneg == rneg) begin
      yneg = (pm != 0) ? pneg : rneg;
      ym   = pm + s;
    end else if (pm > s || (pm == s && exact)) begin
      yneg = pneg;
      ym   = pm - s - (exact ? 64'd0 : 64'd1);
    end else begin
      yneg = rneg;
      ym   = s - pm;
    end
    return scaled_quotient(yneg, ym, den_neg, den);
  endfunction

  function automatic roots_t solve_quadratic(coef_set_t cs);
    roots_t          r;
    longint          a;
    longint          b;
    longint          c;
    longint          disc;
    logic [127:0]    rad;
    logic [127:0]    s;
    logic [127:0]    t;
    logic            exact;
    longint unsigned den;
    longint unsigned pm;
    a = cs.a;
    b = cs.b;
    c = cs.c;
    r.kind = qrs_pkg::KIND_LINEAR;
    r.v1 = '0;
    r.v2 = '0;
    if (a == 0) return r;
    disc = b * b - 4 * a * c;
    rad  = 128'(disc < 0 ? -disc : disc) << 32;
    s = '0;
    for (int i = 40; i >= 0; i--) begin
      t = s | (128'd1 << i);
      if (t * t <= rad) s = t;
    end
    exact = (s * s == rad);
    den = 64'(a < 0 ? -a : a) << 1;
    pm  = 64'(b < 0 ? -b : b) << 16;
    if (disc == 0) begin
      r.kind = qrs_pkg::KIND_EQUAL;
      r.v1 = root_part(b >= 0, pm, 1'b0, 0, 1'b1, a < 0, den);
      r.v2 = r.v1;
    end else if (disc > 0) begin
      r.kind = qrs_pkg::KIND_DISTINCT;
      r.v1 = root_part(b >= 0, pm, 1'b0, 64'(s), exact, a < 0, den);
      r.v2 = root_part(b >= 0, pm, 1'b1, 64'(s), exact, a < 0, den);
    end else begin
      r.kind = qrs_pkg::KIND_COMPLEX;
      r.v1 = root_part(b >= 0, pm, 1'b0, 0, 1'b1, a < 0, den);
      r.v2 = root_part(1'b0, 0, 1'b0, 64'(s), exact, a < 0, den);
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", field, got, want, roots_checked);
    error_count++;
  endtask

  task automatic add_set(int a, int b, int c);
    coef_set_t cs;
    cs.a = qrs_pkg::COEF_W'(a);
    cs.b = qrs_pkg::COEF_W'(b);
    cs.c = qrs_pkg::COEF_W'(c);
    pending_sets.push_back(cs);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_roots.push_back(solve_quadratic('{coef_a, coef_b, coef_c}));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_sets.size() > 0 &&
                     ($urandom_range(0, 9) != 0 || pending_sets.size() < QUIET_TAIL)) begin
          coef_a   <= pending_sets[0].a;
          coef_b   <= pending_sets[0].b;
          coef_c   <= pending_sets[0].c;
          in_valid <= 1'b1;
          void'(pending_sets.pop_front());
        end else begin
          if (pending_sets.size() > 0) send_gap <= $urandom_range(0, 12);
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    roots_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_roots.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = expected_roots.pop_front();
          if (root_kind !== want.kind) report_mismatch("root_kind", root_kind, want.kind);
          if (first_value !== want.v1) report_mismatch("first_value", first_value, want.v1);
          if (second_value !== want.v2) report_mismatch("second_value", second_value, want.v2);
        end
        roots_checked++;
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && roots_checked >= 300) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (pending_sets.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        recv_gap  <= $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int p;
    int q;
    int sg;
    add_set(0, 0, 0);
    add_set(0, -32768, 32767);
    add_set(256, 512, 256);
    add_set(-256, 512, -256);
    add_set(1, 2, 1);
    add_set(256, 0, -256);
    add_set(256, 0, 256);
    add_set(-256, 0, 256);
    add_set(-256, 0, -256);
    add_set(256, 0, 0);
    add_set(-32768, -32768, -32768);
    add_set(32767, 32767, 32767);
    add_set(-32768, 32767, 32767);
    add_set(32767, -32768, -32768);
    add_set(1, -32768, 1);
    add_set(1, 32767, -32768);
    add_set(-1, 0, 32767);
    add_set(256, -768, 512);
    add_set(512, 300, 700);
    add_set(-1, -1, -1);
    for (int i = 0; i < 1550; i++) begin
      case ($urandom_range(0, 5))
        0, 1: add_set($urandom, $urandom, $urandom);
        2: add_set($signed($urandom_range(0, 1023)) - 512, $signed($urandom_range(0, 4095)) - 2048,
                   $signed($urandom_range(0, 1023)) - 512);
        3: begin
          p  = $urandom_range(0, 127);
          q  = $urandom_range(0, 127);
          sg = $urandom_range(0, 1) ? -1 : 1;
          add_set(sg * p * p, ($urandom_range(0, 1) ? -2 : 2) * p * q, sg * q * q);
        end
        4: add_set($urandom_range(0, 1) ? -32768 : 32767, $urandom, $urandom);
        default: add_set($signed($urandom_range(0, 15)) - 8, $urandom, $urandom);
      endcase
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending_sets.size() > 0 || in_valid || expected_roots.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_roots.size() > 0) report_mismatch("results missing", 0, expected_roots.size());
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
